// ===== sv/sbus_frame_decoder_unit_assert.svh =====
// Assertion macros used by the frame decoder controller.
// Each macro expects a clock named clk and a reset named arst_n in scope.
`ifndef SBUS_FRAME_DECODER_UNIT_ASSERT_SVH
`define SBUS_FRAME_DECODER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SFD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SFD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/sfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame decoder package
// Request types, controller/datapath link types and decoding constants.
// ----------------------------------------------------------------------------
package sfd_pkg;

	localparam int FRAME_BYTES = 25;
	localparam int FRAME_W     = FRAME_BYTES * 8;

	localparam int COUNT_W     = 6;
	localparam int CH_W        = 4;
	localparam int RAW_W       = 11;
	localparam int SCL_W       = 16;
	localparam int SW_W        = 2;
	localparam int FRAC_W      = 14;

	// Op codes of the byte request.
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_IDLE = 1'b1;

	// Frame markers.
	localparam logic [7:0] SYNC_BYTE = 8'h0f;
	localparam logic [7:0] END_BYTE  = 8'h00;
	localparam int         END_POS   = 23;

	// Channel groups.
	localparam int NUM_CH    = 15;
	localparam int AXIS_LAST = 4;
	localparam int AUX_LAST  = 6;
	localparam int SW_FIRST  = 7;
	localparam int SW_LAST   = 10;
	localparam int MID_CH    = 9;

	// Reference levels of the raw channel values.
	localparam logic [RAW_W-1:0] LVL_CENTRE = 11'd1024;
	localparam logic [RAW_W-1:0] LVL_LOW    = 11'd240;
	localparam logic [RAW_W-1:0] LVL_HIGH   = 11'd1807;

	// Scale divisors and their reciprocals, 2^(FRAC_W + RECIP_SHIFT) / divisor.
	localparam logic [RAW_W-1:0] DIV_AXIS = 11'd783;
	localparam logic [RAW_W-1:0] DIV_AUX  = 11'd1567;
	localparam int RECIP_SHIFT = 12;
	localparam int RECIP_W     = 17;
	localparam int RECIP_AXIS  = (2 ** (FRAC_W + RECIP_SHIFT)) / 783;
	localparam int RECIP_AUX   = (2 ** (FRAC_W + RECIP_SHIFT)) / 1567;
	localparam int PROD_W      = RAW_W + RECIP_W;
	localparam int Q_W         = 15;
	localparam int N_W         = RAW_W + FRAC_W;

	// Held switch codes.
	localparam logic [SW_W-1:0] SW_UNKNOWN = 2'd0;
	localparam logic [SW_W-1:0] SW_LOW     = 2'd1;
	localparam logic [SW_W-1:0] SW_HIGH    = 2'd2;
	localparam logic [SW_W-1:0] SW_MID     = 2'd3;

	typedef struct packed {
		logic       op;
		logic [7:0] rx_byte;
	} byte_req_t;

	typedef struct packed {
		logic [CH_W-1:0]         channel;
		logic [RAW_W-1:0]        raw_value;
		logic signed [SCL_W-1:0] scaled_value;
		logic [SW_W-1:0]         switch_pos;
		logic                    last;
	} chan_rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic            shift_byte;
		logic            frame_end;
		logic            start;
		logic            mul1;
		logic            mul2;
		logic            emit;
		logic [CH_W-1:0] ch;
	} sfd_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic frame_ok;
		logic out_free;
	} sfd_sts_t;

endpackage

// ===== sv/sfd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame decoder controller
// Sequences byte capture, frame checks and per-channel scaling steps.
// ----------------------------------------------------------------------------
module sfd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	output logic              byte_stall,
	input  sfd_pkg::byte_req_t byte_req,
	input  sfd_pkg::sfd_sts_t  sts,
	output sfd_pkg::sfd_cmd_t  cmd
);
	import sfd_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_MUL1 = 4'b0010,
		S_MUL2 = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	state_t          state_q, state_d;
	logic [CH_W-1:0] ch_q, ch_d;
	logic            acc;

	assign byte_stall = (state_q != S_IDLE);
	assign acc        = byte_valid && !byte_stall;

	always_comb begin
		cmd            = '0;
		cmd.shift_byte = acc && (byte_req.op == OP_BYTE);
		cmd.frame_end  = acc && (byte_req.op == OP_IDLE);
		cmd.start      = cmd.frame_end && sts.frame_ok;
		cmd.mul1       = (state_q == S_MUL1);
		cmd.mul2       = (state_q == S_MUL2);
		cmd.emit       = (state_q == S_FIN) && sts.out_free;
		cmd.ch         = ch_q;
	end

	always_comb begin
		state_d = state_q;
		ch_d    = ch_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.start) begin
					state_d = S_MUL1;
					ch_d    = CH_W'(1);
				end
			end
			S_MUL1: state_d = S_MUL2;
			S_MUL2: state_d = S_FIN;
			S_FIN: begin
				if (sts.out_free) begin
					if (ch_q == CH_W'(NUM_CH)) begin
						state_d = S_IDLE;
					end else begin
						state_d = S_MUL1;
						ch_d    = ch_q + CH_W'(1);
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ch_q    <= '0;
		end else begin
			state_q <= state_d;
			ch_q    <= ch_d;
		end
	end

`include "sbus_frame_decoder_unit_assert.svh"

	`SFD_ASSERT_NEXT(a_start_goes_busy, cmd.start, state_q == S_MUL1 && ch_q == CH_W'(1), "accepted frame did not start channel one")
	`SFD_ASSERT_NEXT(a_last_ends, cmd.emit && ch_q == CH_W'(NUM_CH), state_q == S_IDLE, "frame did not end after the last channel")
	`SFD_ASSERT_NEXT(a_fin_waits, state_q == S_FIN && !sts.out_free, state_q == S_FIN && $stable(ch_q), "result step moved on while the output was full")
	`SFD_ASSERT_SAME(a_ch_range, state_q != S_IDLE, ch_q >= CH_W'(1) && ch_q <= CH_W'(NUM_CH), "channel counter out of range while busy")

endmodule

// ===== sv/sfd_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame decoder datapath
// Byte shift line, byte counter, channel scaling and switch code registers.
// ----------------------------------------------------------------------------
module sfd_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  sfd_pkg::byte_req_t byte_req,
	input  sfd_pkg::sfd_cmd_t  cmd,
	output sfd_pkg::sfd_sts_t  sts,
	output logic               chan_valid,
	input  logic               chan_stall,
	output sfd_pkg::chan_rsp_t chan_rsp
);
	import sfd_pkg::*;

	logic [FRAME_W-1:0]  frame_q;
	logic [COUNT_W-1:0]  count_q;
	logic [SW_W-1:0]     sw_q [SW_LAST-SW_FIRST+1];

	// Stage one: raw value, magnitude and reciprocal product.
	logic [RAW_W-1:0]  raw_s1, mag_s1, div_s1;
	logic              neg_s1, scl_s1;
	logic [PROD_W-1:0] prod_s1;
	// Stage two: quotient estimate and its back product.
	logic [Q_W-1:0]    qest_s2;
	logic [N_W-1:0]    back_s2;

	logic [RAW_W-1:0]   raw, lvl, mag, div;
	logic [RAW_W:0]     diff;
	logic [RECIP_W-1:0] recip;
	logic               is_axis, is_scl;
	logic [N_W-1:0]     rem;
	logic [Q_W-1:0]     q;
	logic [SCL_W-1:0]   scaled;
	logic               is_sw;
	logic [SW_W-1:0]    sw_idx, sw_next;
	logic               rsp_valid_q;
	chan_rsp_t          rsp_q;

	assign raw = frame_q[RAW_W-1:0];

	assign sts.frame_ok = (count_q == COUNT_W'(FRAME_BYTES))
		&& (frame_q[7:0] == SYNC_BYTE)
		&& (frame_q[END_POS*8 +: 8] == END_BYTE);
	assign sts.out_free = !rsp_valid_q || !chan_stall;

	// The newest byte enters at the top, so after a full frame byte 0 sits lowest.
	always_ff @(posedge clk) begin
		if (cmd.shift_byte) begin
			frame_q <= {byte_req.rx_byte, frame_q[FRAME_W-1:8]};
		end else if (cmd.start) begin
			frame_q <= {8'h00, frame_q[FRAME_W-1:8]};
		end else if (cmd.emit) begin
			frame_q <= {{RAW_W{1'b0}}, frame_q[FRAME_W-1:RAW_W]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.frame_end) begin
			count_q <= '0;
		end else if (cmd.shift_byte && count_q != '1) begin
			count_q <= count_q + COUNT_W'(1);
		end
	end

	always_comb begin
		is_axis = (cmd.ch <= CH_W'(AXIS_LAST));
		is_scl  = (cmd.ch <= CH_W'(AUX_LAST));
		lvl     = is_axis ? LVL_CENTRE : LVL_LOW;
		div     = is_axis ? DIV_AXIS : DIV_AUX;
		recip   = is_axis ? RECIP_W'(RECIP_AXIS) : RECIP_W'(RECIP_AUX);
		diff    = {1'b0, raw} - {1'b0, lvl};
		mag     = diff[RAW_W] ? RAW_W'(~diff + (RAW_W+1)'(1)) : diff[RAW_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.mul1) begin
			raw_s1  <= raw;
			mag_s1  <= mag;
			div_s1  <= div;
			neg_s1  <= diff[RAW_W];
			scl_s1  <= is_scl;
			prod_s1 <= {{RECIP_W{1'b0}}, mag} * {{RAW_W{1'b0}}, recip};
		end
		if (cmd.mul2) begin
			qest_s2 <= prod_s1[RECIP_SHIFT +: Q_W];
			back_s2 <= N_W'({{RAW_W{1'b0}}, prod_s1[RECIP_SHIFT +: Q_W]}
				* {{Q_W{1'b0}}, div_s1});
		end
	end

	// The estimate is at most one below the true quotient.
	always_comb begin
		rem    = {mag_s1, {FRAC_W{1'b0}}} - back_s2;
		q      = qest_s2 + Q_W'(rem >= N_W'(div_s1));
		scaled = neg_s1 ? (SCL_W'(0) - SCL_W'(q)) : SCL_W'(q);
	end

	always_comb begin
		is_sw   = (cmd.ch >= CH_W'(SW_FIRST)) && (cmd.ch <= CH_W'(SW_LAST));
		sw_idx  = SW_W'(cmd.ch - CH_W'(SW_FIRST));
		sw_next = sw_q[sw_idx];
		if (raw_s1 == LVL_LOW) begin
			sw_next = SW_LOW;
		end else if (raw_s1 == LVL_HIGH) begin
			sw_next = SW_HIGH;
		end else if (cmd.ch == CH_W'(MID_CH) && raw_s1 == LVL_CENTRE) begin
			sw_next = SW_MID;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SW_LAST - SW_FIRST + 1; i++) begin
				sw_q[i] <= SW_UNKNOWN;
			end
		end else if (cmd.emit && is_sw) begin
			sw_q[sw_idx] <= sw_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			rsp_valid_q <= 1'b1;
		end else if (!chan_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp_q.channel      <= cmd.ch;
			rsp_q.raw_value    <= raw_s1;
			rsp_q.scaled_value <= scl_s1 ? scaled : '0;
			rsp_q.switch_pos   <= is_sw ? sw_next : SW_UNKNOWN;
			rsp_q.last         <= (cmd.ch == CH_W'(NUM_CH));
		end
	end

	assign chan_valid = rsp_valid_q;
	assign chan_rsp   = rsp_q;

endmodule

// ===== sv/sbus_frame_decoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial bus frame decoder
// Collects frame bytes, checks the frame on line idle and emits 15 channels.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | request
//  byte    | in        | byte_valid / byte_stall | byte_req (op, rx_byte)
//  chan    | out       | chan_valid / chan_stall | chan_rsp (one channel result)
//
// A data byte or a rejected idle request is taken without raising byte_stall.
// An accepted frame is scaled channel by channel through the MUL1, MUL2 and FIN steps
// of the scaling unit's two-step reciprocal multiply; byte_stall is high meanwhile.
// A stalled result holds the channel step until the output is free again.
// Reset clears the byte count, the switch codes and the controller; the frame
// shift register is not reset.
module sbus_frame_decoder_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_stall,
	input  sfd_pkg::byte_req_t byte_req,
	output logic               chan_valid,
	input  logic               chan_stall,
	output sfd_pkg::chan_rsp_t chan_rsp
);
	import sfd_pkg::*;

	sfd_cmd_t cmd;
	sfd_sts_t sts;

	sfd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_req   (byte_req),
		.sts        (sts),
		.cmd        (cmd)
	);

	sfd_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_req   (byte_req),
		.cmd        (cmd),
		.sts        (sts),
		.chan_valid (chan_valid),
		.chan_stall (chan_stall),
		.chan_rsp   (chan_rsp)
	);

endmodule

// ===== sim/sbus_frame_decoder_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial bus frame decoder testbench
// Drives byte and line-idle requests with random gaps, stalls the channel
// output at random and once for a long hold-off, and checks every channel
// result against a frame decoder model kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module sbus_frame_decoder_unit_tb;
	import sfd_pkg::*;

	localparam int CLK_PERIOD     = 20;
	localparam int STORE_BYTES    = 32;
	localparam int COUNT_MAX      = 63;
	localparam int NUM_ITEMS      = 120;
	localparam int HOLD_CYCLES    = 300;
	localparam int DRAIN_CYCLES   = 60;
	localparam int TIMEOUT_CYCLES = 200000;
	localparam int REPORT_LIMIT   = 10;

	typedef logic [7:0] byte_seq_t[$];
	typedef logic [RAW_W-1:0] level_set_t[NUM_CH];

	typedef enum int {
		FK_GOOD,
		FK_BAD_SYNC,
		FK_BAD_END,
		FK_SHORT,
		FK_LONG,
		FK_LONE_IDLE
	} frame_kind_t;

	class sfd_scoreboard;
		logic [7:0]      rx_bytes[STORE_BYTES];
		int unsigned     rx_count;
		logic [SW_W-1:0] held_sw[4];
		chan_rsp_t       pending_channels[$];
		int              failures;
		int              requests_seen;
		int              frames_decoded;
		int              frames_dropped;
		int              channels_checked;

		function new();
			foreach (rx_bytes[i]) rx_bytes[i] = '0;
			foreach (held_sw[i]) held_sw[i] = SW_UNKNOWN;
			rx_count         = 0;
			failures         = 0;
			requests_seen    = 0;
			frames_decoded   = 0;
			frames_dropped   = 0;
			channels_checked = 0;
		endfunction

		function int pending();
			return pending_channels.size();
		endfunction

		// Signed Q2.14 of (raw - offset) / divisor, truncated toward zero.
		function int q14_ratio(logic [RAW_W-1:0] raw, logic [RAW_W-1:0] offset,
				logic [RAW_W-1:0] divisor);
			return (int'(raw) - int'(offset)) * (1 << FRAC_W) / int'(divisor);
		endfunction

		function void decode_frame();
			logic [FRAME_W-1:0] bits;
			logic [RAW_W-1:0]   raw;
			chan_rsp_t          want;
			int                 k;
			for (int i = 0; i < FRAME_BYTES; i++) bits[8*i +: 8] = rx_bytes[i];
			for (int ch = 1; ch <= NUM_CH; ch++) begin
				raw = bits[8 + RAW_W*(ch-1) +: RAW_W];
				want = '0;
				want.channel   = CH_W'(ch);
				want.raw_value = raw;
				if (ch <= AXIS_LAST)
					want.scaled_value = SCL_W'(q14_ratio(raw, LVL_CENTRE, DIV_AXIS));
				else if (ch <= AUX_LAST)
					want.scaled_value = SCL_W'(q14_ratio(raw, LVL_LOW, DIV_AUX));
				else if (ch <= SW_LAST) begin
					k = ch - SW_FIRST;
					// Any level other than the recognised ones keeps the held code.
					if (raw == LVL_LOW)
						held_sw[k] = SW_LOW;
					else if (raw == LVL_HIGH)
						held_sw[k] = SW_HIGH;
					else if (ch == MID_CH && raw == LVL_CENTRE)
						held_sw[k] = SW_MID;
					want.switch_pos = held_sw[k];
				end
				want.last = (ch == NUM_CH);
				pending_channels.push_back(want);
			end
		endfunction

		function void absorb_request(byte_req_t req);
			int unsigned count;
			requests_seen++;
			if (req.op == OP_BYTE) begin
				// The count saturates; bytes past the store are counted but dropped.
				if (rx_count < COUNT_MAX) begin
					if (rx_count < STORE_BYTES)
						rx_bytes[rx_count] = req.rx_byte;
					rx_count++;
				end
			end else begin
				count    = rx_count;
				rx_count = 0;
				if (count == FRAME_BYTES && rx_bytes[0] == SYNC_BYTE
						&& rx_bytes[END_POS] == END_BYTE) begin
					frames_decoded++;
					decode_frame();
				end else
					frames_dropped++;
			end
		endfunction

		function void check_result(chan_rsp_t got);
			chan_rsp_t want;
			bit        bad;
			if (pending_channels.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("ERROR: unexpected result ch %0d raw %0d scaled %0d sw %0d last %0d",
						got.channel, got.raw_value, $signed(got.scaled_value),
						got.switch_pos, got.last);
				return;
			end
			want = pending_channels.pop_front();
			channels_checked++;
			bad = (got.channel !== want.channel) || (got.raw_value !== want.raw_value)
				|| (got.scaled_value !== want.scaled_value)
				|| (got.switch_pos !== want.switch_pos) || (got.last !== want.last);
			if (bad) begin
				failures++;
				if (failures <= REPORT_LIMIT) begin
					$display("ERROR: expected ch %0d raw %0d scaled %0d sw %0d last %0d",
						want.channel, want.raw_value, $signed(want.scaled_value),
						want.switch_pos, want.last);
					$display("       got      ch %0d raw %0d scaled %0d sw %0d last %0d",
						got.channel, got.raw_value, $signed(got.scaled_value),
						got.switch_pos, got.last);
				end
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      byte_valid;
	logic      byte_stall;
	byte_req_t byte_req;
	logic      chan_valid;
	logic      chan_stall;
	chan_rsp_t chan_rsp;

	bit quiet;
	bit hold_req;

	sfd_scoreboard sb = new();

	sbus_frame_decoder_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_req   (byte_req),
		.chan_valid (chan_valid),
		.chan_stall (chan_stall),
		.chan_rsp   (chan_rsp)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD/2) clk = ~clk;
	end

	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("sbus_frame_decoder_unit verification failed");
		$finish;
	end

	// Channel receiver: random stalls, plus one long hold-off on request.
	initial begin
		int hold_left;
		chan_stall = 1'b0;
		hold_left  = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				chan_stall <= 1'b1;
			end else
				chan_stall <= !quiet && ($urandom_range(99) < 30);
		end
	end

	always @(posedge clk) begin
		if (arst_n && chan_valid && !chan_stall)
			sb.check_result(chan_rsp);
	end

	task automatic offer_request(input logic op, input logic [7:0] data);
		byte_req_t req;
		req.op      = op;
		req.rx_byte = data;
		while (!quiet && $urandom_range(99) < 30) begin
			@(negedge clk);
			byte_valid <= 1'b0;
		end
		@(negedge clk);
		byte_valid <= 1'b1;
		byte_req   <= req;
		do @(posedge clk); while (byte_stall);
		sb.absorb_request(req);
	endtask

	function automatic logic [RAW_W-1:0] pick_level();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return LVL_LOW;
			3: return LVL_HIGH;
			4: return LVL_CENTRE;
			default: return RAW_W'($urandom);
		endcase
	endfunction

	function automatic level_set_t random_levels();
		level_set_t levels;
		foreach (levels[i]) levels[i] = pick_level();
		return levels;
	endfunction

	// Packs fifteen levels into a well-formed frame; spare bits are random.
	function automatic byte_seq_t frame_bytes(input level_set_t levels);
		logic [FRAME_W-1:0] bits;
		byte_seq_t          seq;
		for (int i = 0; i < FRAME_BYTES; i++) bits[8*i +: 8] = 8'($urandom);
		bits[7:0] = SYNC_BYTE;
		for (int ch = 1; ch <= NUM_CH; ch++)
			bits[8 + RAW_W*(ch-1) +: RAW_W] = levels[ch-1];
		bits[8*END_POS +: 8] = END_BYTE;
		for (int i = 0; i < FRAME_BYTES; i++) seq.push_back(bits[8*i +: 8]);
		return seq;
	endfunction

	task automatic offer_frame(input frame_kind_t kind, input level_set_t levels);
		byte_seq_t seq;
		int        n;
		seq = frame_bytes(levels);
		case (kind)
			FK_BAD_SYNC: seq[0] = seq[0] ^ 8'($urandom_range(255, 1));
			FK_BAD_END: seq[END_POS] = 8'($urandom_range(255, 1));
			FK_SHORT: begin
				n   = $urandom_range(FRAME_BYTES - 2, 0);
				seq = seq[0:n];
			end
			// Long frames straddle the end of the store.
			FK_LONG: repeat ($urandom_range(STORE_BYTES + 2 - FRAME_BYTES, 1))
				seq.push_back(8'($urandom));
			FK_LONE_IDLE: seq.delete();
			default: ;
		endcase
		foreach (seq[i]) offer_request(OP_BYTE, seq[i]);
		offer_request(OP_IDLE, 8'($urandom));
	endtask

	initial begin
		frame_kind_t opening[6];
		level_set_t  levels;
		frame_kind_t kind;
		int          good_frames;
		int          iter;

		opening    = '{FK_GOOD, FK_SHORT, FK_BAD_SYNC, FK_LONG, FK_BAD_END, FK_LONE_IDLE};
		arst_n     = 1'b0;
		byte_valid = 1'b0;
		byte_req   = '0;
		quiet      = 1'b0;
		hold_req   = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Idle with nothing collected, then one frame with the corner levels,
		// including a centre level on a switch channel that has no middle code.
		offer_request(OP_IDLE, 8'hff);
		levels = '{11'd0, 11'h7ff, LVL_CENTRE, LVL_CENTRE - 11'd1, LVL_LOW, 11'd0,
			LVL_LOW, LVL_HIGH, LVL_CENTRE, LVL_CENTRE, 11'd0, 11'h7ff,
			LVL_HIGH, LVL_LOW, 11'h7ff};
		offer_frame(FK_GOOD, levels);

		good_frames = 0;
		iter        = 0;
		while (sb.requests_seen < NUM_ITEMS) begin
			quiet = (iter >= 1 && iter < 4);
			if (iter < 6)
				kind = opening[iter];
			else if ($urandom_range(99) < 70)
				kind = FK_GOOD;
			else
				kind = frame_kind_t'($urandom_range(int'(FK_LONE_IDLE), int'(FK_BAD_SYNC)));
			if (kind == FK_GOOD) begin
				// The first random frame meets a long output hold-off, so the
				// decoder backs up and stalls the byte requests behind it.
				if (good_frames == 0)
					hold_req = 1'b1;
				good_frames++;
			end
			offer_frame(kind, random_levels());
			iter++;
		end
		quiet = 1'b0;
		@(negedge clk);
		byte_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d requests: %0d frames decoded, %0d dropped, %0d channels checked.",
			sb.requests_seen, sb.frames_decoded, sb.frames_dropped, sb.channels_checked);
		$display("Stimulus took in bad markers, short and long frames and a %0d-cycle hold-off.",
			HOLD_CYCLES);
		if (sb.failures == 0 && sb.pending() == 0)
			$display("sbus_frame_decoder_unit verification clean");
		else
			$display("sbus_frame_decoder_unit verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/sfd_pkg.sv
sv/sfd_ctrl.sv
sv/sfd_datapath.sv
sv/sbus_frame_decoder_unit.sv
sim/sbus_frame_decoder_unit_tb.sv
